FILE: hw/rtl/signed_int_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Concurrent assertion wrappers, with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Checked only while reset is low.
`define SIDTA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SIDTA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/sidta_pkg.sv
// ---------------------------------------------------------------------------
// sidta_pkg
// Shared types, constants and the double-dabble step for the decimal
// text generator.
// ---------------------------------------------------------------------------
`default_nettype none

package sidta_pkg;

   localparam int MAG_W           = 32;
   localparam int DIGITS          = 10;
   localparam int BCD_W           = 4 * DIGITS;
   localparam int DIG_IDX_W       = $clog2(DIGITS);
   localparam int STEPS_PER_STAGE = 8;
   localparam int DABBLE_STAGES   = MAG_W / STEPS_PER_STAGE;

   localparam logic [7:0] DIGIT_ZERO = 8'd48;
   localparam logic [7:0] MINUS_SIGN = 8'd45;

   // Conversion word carried down the pipe.
   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
      logic [MAG_W-1:0] bin;
   } conv_type;

   // One stage worth of shift-and-add-3 steps.
   function automatic conv_type dabble_steps(input conv_type x);
      conv_type         r;
      logic [BCD_W-1:0] b;
      logic [MAG_W-1:0] m;
      r = x;
      b = x.bcd;
      m = x.bin;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], m[MAG_W-1]};
         m = {m[MAG_W-2:0], 1'b0};
      end
      r.bcd = b;
      r.bin = m;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sidta_dabble.sv
// ---------------------------------------------------------------------------
// sidta_dabble
// One binary-to-BCD pipe stage with valid/ready stall handling.
// ---------------------------------------------------------------------------
`default_nettype none

module sidta_dabble (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 up_valid,
   input  sidta_pkg::conv_type up_data,
   output logic                up_ready,
   output logic                dn_valid,
   input  wire                 dn_ready,
   output sidta_pkg::conv_type dn_data
);

   logic                valid_ff, valid_in;
   sidta_pkg::conv_type data_ff, data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign data_in  = sidta_pkg::dabble_steps(up_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload only moves on an accepted beat.
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sidta_serial.sv
// ---------------------------------------------------------------------------
// sidta_serial
// Finds the leading digit and sends sign and digits one beat per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sidta_serial (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 ld_valid,
   input  sidta_pkg::conv_type ld_data,
   output logic                ld_ready,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_character,
   output logic                rsp_is_last
);

   logic                              active_ff, active_in;
   logic                              sign_ff, sign_in;
   logic [sidta_pkg::DIG_IDX_W-1:0]   idx_ff, idx_in;
   logic [3:0]                        dig_ff [sidta_pkg::DIGITS];
   logic                              strobe_ff, strobe_in;
   logic [7:0]                        char_ff, char_in;
   logic                              last_ff, last_in;
   logic [sidta_pkg::DIG_IDX_W-1:0]   top;
   logic                              last_digit;
   logic                              load;

   // Highest nonzero digit; zero keeps one digit.
   always_comb begin
      top = '0;
      for (int i = 0; i < sidta_pkg::DIGITS; i++) begin
         if (ld_data.bcd[i*4 +: 4] != 4'd0) begin
            top = sidta_pkg::DIG_IDX_W'(i);
         end
      end
   end

   assign last_digit = active_ff && !sign_ff && (idx_ff == '0);
   assign ld_ready   = !active_ff || last_digit;
   assign load       = ld_valid && ld_ready;

   assign strobe_in = active_ff;
   assign char_in   = sign_ff ? sidta_pkg::MINUS_SIGN
                              : sidta_pkg::DIGIT_ZERO + {4'd0, dig_ff[idx_ff]};
   assign last_in   = last_digit;

   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      idx_in    = idx_ff;
      if (load) begin
         active_in = 1'b1;
         sign_in   = ld_data.neg;
         idx_in    = top;
      end else if (active_ff) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - sidta_pkg::DIG_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sign_ff   <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (load) begin
         for (int i = 0; i < sidta_pkg::DIGITS; i++) begin
            dig_ff[i] <= ld_data.bcd[i*4 +: 4];
         end
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_is_last   = last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ---------------------------------------------------------------------------
// Throughput: one beat per character, 1 to 11 characters per item; the
//   single-character output port sets this, the pipe itself takes one
//   item per cycle while the serializer keeps up.
// busy rises when the pipe backs up behind the serializer.
// Reset (synchronous, active high) empties the pipe and the serializer.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire signed [31:0] req_value,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_character,
   output logic              rsp_is_last
);

   localparam int NS = sidta_pkg::DABBLE_STAGES;

   // Input register: sign and magnitude. The magnitude is formed as an
   // unsigned negate, so the most negative value maps to 2^31 cleanly.
   logic                in_valid_ff, in_valid_in;
   sidta_pkg::conv_type in_data_ff, in_data_in;
   logic                in_ready;
   logic                accept;

   // Pipe plumbing: index k feeds dabble stage k, index NS feeds the
   // serializer.
   logic                stg_valid [NS+1];
   sidta_pkg::conv_type stg_data  [NS+1];
   logic                stg_ready [NS+1];

   assign accept = start && !busy;
   assign busy   = !in_ready;

   assign in_ready    = !in_valid_ff || stg_ready[0];
   assign in_valid_in = in_ready ? start : in_valid_ff;

   always_comb begin
      in_data_in.neg = req_value[31];
      in_data_in.bcd = '0;
      in_data_in.bin = req_value[31] ? (32'd0 - 32'(req_value)) : 32'(req_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= in_data_in;
      end
   end

   assign stg_valid[0] = in_valid_ff;
   assign stg_data[0]  = in_data_ff;

   // Four stages of eight shift-and-add-3 steps: 32 steps in all turn the
   // magnitude into ten BCD digits.
   for (genvar k = 0; k < NS; k++) begin : g_dabble
      sidta_dabble u_dabble (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[k]),
         .up_data  (stg_data[k]),
         .up_ready (stg_ready[k]),
         .dn_valid (stg_valid[k+1]),
         .dn_ready (stg_ready[k+1]),
         .dn_data  (stg_data[k+1])
      );
   end

   // Serializer: strips leading zeros, sends '-' first for negatives and
   // flags the final digit. It takes the next item in the same cycle as it registers
   // the last digit of the current one, so runs go out back to back.
   sidta_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .ld_valid      (stg_valid[NS]),
      .ld_data       (stg_data[NS]),
      .ld_ready      (stg_ready[NS]),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/sidta_checker.sv
// ---------------------------------------------------------------------------
// sidta_checker
// Port-level checks on the decimal text stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_assert.svh"

module sidta_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire signed [31:0] req_value,
   input wire               rsp_strobe,
   input wire [7:0]         rsp_character,
   input wire               rsp_is_last
);

   logic is_minus;
   logic is_digit;
   logic beat_minus;
   logic lead_digit;

   assign is_minus   = rsp_character == sidta_pkg::MINUS_SIGN;
   assign is_digit   = (rsp_character >= sidta_pkg::DIGIT_ZERO)
                       && (rsp_character <= sidta_pkg::DIGIT_ZERO + 8'd9);
   assign beat_minus = rsp_strobe && is_minus;
   assign lead_digit = rsp_strobe && is_digit && (rsp_character != sidta_pkg::DIGIT_ZERO);

   `SIDTA_ASSERT(a_char_legal, clock, reset, rsp_strobe |-> (is_minus || is_digit), "bad char")
   `SIDTA_ASSERT(a_minus_not_last, clock, reset, beat_minus |-> !rsp_is_last, "minus ends run")
   `SIDTA_ASSERT(a_minus_then_lead, clock, reset, beat_minus |=> lead_digit, "no lead digit")
   `SIDTA_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!rsp_strobe && !busy), "reset exit")
   `SIDTA_ASSERT(a_req_known, clock, reset, (start && !busy) |-> !$isunknown(req_value), "X value")

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_checker (.*);

`default_nettype wire

FILE: sim/signed_int_to_decimal_ascii_test.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Drives signed 32-bit values into the decimal text generator and checks
// every emitted character and its last-character flag against a local
// predictor. Covers corner values, then random values of every length
// under several sender idle patterns, with a full drain pause per phase.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

   // One predicted output beat.
   typedef struct {
      logic [7:0] character;
      logic       is_last;
   } text_char_type;

   localparam int RANDOM_PHASES   = 3;
   localparam int ITEMS_PER_PHASE = 67;
   localparam int CORNER_COUNT    = 20;
   localparam int SETTLE_CYCLES   = 16;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic [31:0] req_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_character;
   logic        rsp_is_last;

   // Values waiting to be sent, each with its own idle odds (percent) and
   // a flag that holds it back until every expected character has come.
   logic [31:0] pending_values[$];
   int          pending_idle_pct[$];
   bit          pending_drain[$];

   // Characters predicted from accepted values, oldest first.
   text_char_type expected_text[$];

   bit          req_taken = 1'b0;   // last rising edge accepted a beat
   int          error_count = 0;
   int          values_sent = 0;
   int          negative_values = 0;
   int          zero_values = 0;
   int          eleven_char_runs = 0;
   int          chars_checked = 0;

   signed_int_to_decimal_ascii u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_is_last   (rsp_is_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor: spells one value as decimal text and queues the characters.
   // The magnitude is taken as unsigned 32 bits, so 0x80000000 negates to
   // 2147483648 without overflow.
   // ------------------------------------------------------------------------
   function automatic void spell_decimal(input logic [31:0] word);
      logic [31:0]   mag;
      logic [3:0]    digit_buf [10];
      int            n;
      text_char_type c;
      mag = word[31] ? (32'd0 - word) : word;
      n   = 0;
      do begin
         digit_buf[n] = 4'(mag % 32'd10);
         mag = mag / 32'd10;
         n++;
      end while (mag != 0);
      if (word[31]) begin
         c.character = sidta_pkg::MINUS_SIGN;
         c.is_last   = 1'b0;
         expected_text.push_back(c);
         negative_values++;
      end
      for (int i = n - 1; i >= 0; i--) begin
         c.character = sidta_pkg::DIGIT_ZERO + 8'(digit_buf[i]);
         c.is_last   = (i == 0);
         expected_text.push_back(c);
      end
      if (word == 0) zero_values++;
      if (word[31] && n == 10) eleven_char_runs++;
      values_sent++;
   endfunction

   // Random value: mostly a uniformly chosen digit count, so short and long
   // runs are equally common; some raw 32-bit words, powers of ten and 99..9.
   function automatic logic [31:0] pick_value();
      int unsigned lo;
      int unsigned hi;
      int          ndig;
      logic [31:0] v;
      ndig = $urandom_range(10, 1);
      lo   = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi   = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
      case ($urandom_range(9))
         0: v = $urandom;
         1: v = lo;                       // 10^k
         2: v = (ndig == 1) ? 32'd0 : lo - 1;  // 99..9
         default: v = $urandom_range(hi, (ndig == 1) ? 0 : lo);
      endcase
      if ($urandom_range(1) == 1) v = 32'd0 - v;
      return v;
   endfunction

   function automatic void queue_value(input logic [31:0] v, input int idle_pct,
                                       input bit drain);
      pending_values.push_back(v);
      pending_idle_pct.push_back(idle_pct);
      pending_drain.push_back(drain);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: changes inputs on the falling edge. A beat on start is held
   // until the rising edge that accepts it (start high, busy low).
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_values.size() != 0
             && !(pending_drain[0] && expected_text.size() != 0)
             && $urandom_range(99) >= pending_idle_pct[0]) begin
            start     <= 1'b1;
            req_value <= pending_values[0];
         end else begin
            // idle: value lines carry noise while start is low
            start     <= 1'b0;
            req_value <= $urandom;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: samples on the rising edge. Output beats are checked before
   // a newly accepted value is predicted, so a stray strobe is never
   // matched against characters that could not have been produced yet.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               $error("character %0d (last %0b) with no beat expected",
                      rsp_character, rsp_is_last);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character mismatch: expected %0d, got %0d",
                         want.character, rsp_character);
                  error_count++;
               end
               if (rsp_is_last !== want.is_last) begin
                  $error("is_last mismatch: expected %0b, got %0b",
                         want.is_last, rsp_is_last);
                  error_count++;
               end
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            spell_decimal(req_value);
            void'(pending_values.pop_front());
            void'(pending_idle_pct.pop_front());
            void'(pending_drain.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      logic [31:0] corner_values [CORNER_COUNT];
      int          phase_idle [RANDOM_PHASES];
      corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                        32'd100, -32'sd100, 32'd999_999_999, 32'd1_000_000_000,
                        -32'sd1_000_000_000, 32'd2_147_483_647,
                        -32'sd2_147_483_647, 32'h8000_0000, 32'd1_234_567_890,
                        -32'sd1_234_567_890, 32'h5555_5555, 32'hAAAA_AAAA,
                        -32'sd7};
      // back to back, light gaps, heavy gaps
      phase_idle = '{0, 18, 65};

      // corners: first half back to back, second half with gaps
      for (int i = 0; i < CORNER_COUNT; i++)
         queue_value(corner_values[i], (i < CORNER_COUNT / 2) ? 0 : 40, 1'b0);

      // each phase opens after a full drain; a few random drains inside
      for (int p = 0; p < RANDOM_PHASES; p++)
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_value(pick_value(), phase_idle[p],
                        (i == 0) || ($urandom_range(99) < 3));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || expected_text.size() != 0)
         @(posedge clock);
      // catch any trailing beat the block should not produce
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d negative, %0d zero, %0d of eleven chars),",
               values_sent, negative_values, zero_values, eleven_char_runs);
      $display("checked %0d characters under back-to-back and idle-gap traffic.",
               chars_checked);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sidta_pkg.sv
hw/rtl/sidta_dabble.sv
hw/rtl/sidta_serial.sv
hw/rtl/signed_int_to_decimal_ascii.sv
hw/rtl/sidta_checker.sv
sim/signed_int_to_decimal_ascii_test.sv
